[src/edof_pkg.sv]
// types, constants and helpers shared by the edit distance filter
package edof_pkg;

   localparam int DIST_W = 6;
   localparam int CHAR_W = 8;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic MODE_QUERY = 1'b0;
   localparam logic MODE_CAND  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [CHAR_W-1:0] char_byte;
      logic              word_end;
      logic              no_char;
   } req_beat_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              is_one_edit;
      logic              length_overflow;
   } rsp_beat_type;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] ch;
      logic [DIST_W-1:0] diag;
      logic [DIST_W-1:0] left;
   } wave_type;

   typedef struct packed {
      logic              init;
      logic              load;
      logic [CHAR_W-1:0] load_char;
   } cell_ctrl_type;

   function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
      sat_inc = (v == DIST_MAX) ? DIST_MAX : v + 1'b1;
   endfunction

endpackage

[src/edof_cell.sv]
// one systolic cell: holds a query character and its column of the distance row
module edof_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  edof_pkg::cell_ctrl_type       ctrl,
   input  logic [edof_pkg::DIST_W-1:0]   init_value,
   input  edof_pkg::wave_type            wave_in,
   output edof_pkg::wave_type            wave_out,
   output logic [edof_pkg::DIST_W-1:0]   dp_out
);
   import edof_pkg::*;

   logic [CHAR_W-1:0] char_ff;
   logic [DIST_W-1:0] dp_ff;
   wave_type          wave_out_ff;

   logic [DIST_W-1:0] from_up;
   logic [DIST_W-1:0] from_left;
   logic [DIST_W-1:0] from_diag;
   logic [DIST_W-1:0] best;

   always_comb begin
      from_up   = sat_inc(dp_ff);
      from_left = sat_inc(wave_in.left);
      from_diag = (char_ff == wave_in.ch) ? wave_in.diag : sat_inc(wave_in.diag);
      best      = from_up;
      if (from_left < best) begin
         best = from_left;
      end
      if (from_diag < best) begin
         best = from_diag;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         char_ff <= ctrl.load_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_ff             <= init_value;
         wave_out_ff.valid <= 1'b0;
      end else if (ctrl.init) begin
         dp_ff             <= init_value;
         wave_out_ff.valid <= 1'b0;
      end else if (wave_in.valid) begin
         dp_ff       <= best;
         wave_out_ff <= '{valid: 1'b1, ch: wave_in.ch, diag: dp_ff, left: best};
      end else begin
         wave_out_ff.valid <= 1'b0;
      end
   end

   assign wave_out = wave_out_ff;
   assign dp_out   = dp_ff;

endmodule

[src/edit_distance_one_filter.sv]
// top level: query loader, candidate sequencer and the chain of distance cells
// a query byte loads one cell's character; a candidate byte injects a wavefront
// that walks the cell chain one cell per cycle, and the input stays closed meanwhile
// a word end posts the result from the finish state; an empty item without one stays idle
// the result register lets the next item in while a result waits
// synchronous active-high reset clears control state and sets the row to 0..n
module edit_distance_one_filter #(
   parameter int MAX_LEN = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  edof_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output edof_pkg::rsp_beat_type rsp_data
);
   import edof_pkg::*;

   localparam int IDX_W = $clog2(MAX_LEN + 1);
   localparam logic [DIST_W-1:0] MAX_LEN_V = DIST_W'(MAX_LEN);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [DIST_W-1:0] qlen_ff, qlen_in;
   logic [DIST_W-1:0] clen_ff, clen_in;
   logic              ovf_ff, ovf_in;
   logic              closed_ff, closed_in;
   logic [DIST_W-1:0] dp0_ff, dp0_in;
   logic [DIST_W-1:0] cnt_ff, cnt_in;
   logic              last_ff, last_in;
   wave_type          inj_ff, inj_in;
   rsp_beat_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              cell_init;
   logic              char_load;
   logic [DIST_W-1:0] char_idx;
   logic [DIST_W-1:0] q_base;
   logic [DIST_W-1:0] dp_base;
   logic [DIST_W-1:0] cl_base;
   logic [DIST_W-1:0] cl_next;
   logic [DIST_W-1:0] result_dist;

   wave_type          wave [0:MAX_LEN-1];
   logic [DIST_W-1:0] dp_vec [0:MAX_LEN];

   assign req_ready   = (state_ff == ST_IDLE);
   assign result_dist = dp_vec[qlen_ff[IDX_W-1:0]];

   always_comb begin
      state_in     = state_ff;
      qlen_in      = qlen_ff;
      clen_in      = clen_ff;
      ovf_in       = ovf_ff;
      closed_in    = closed_ff;
      dp0_in       = dp0_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      inj_in       = inj_ff;
      inj_in.valid = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cell_init    = 1'b0;
      char_load    = 1'b0;
      char_idx     = qlen_ff;
      q_base       = closed_ff ? '0 : qlen_ff;
      dp_base      = closed_ff ? dp0_ff : '0;
      cl_base      = closed_ff ? clen_ff : '0;
      cl_next      = sat_inc(cl_base);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.mode == MODE_QUERY) begin
                  qlen_in   = q_base;
                  closed_in = 1'b0;
                  if (closed_ff) begin
                     ovf_in  = 1'b0;
                     clen_in = '0;
                  end
                  if (!req_data.no_char) begin
                     if (q_base < MAX_LEN_V) begin
                        char_load = 1'b1;
                        char_idx  = q_base;
                        qlen_in   = q_base + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  if (req_data.word_end) begin
                     closed_in = 1'b1;
                     cell_init = 1'b1;
                     dp0_in    = '0;
                     clen_in   = '0;
                  end
               end else begin
                  // candidate beat, closing an open query first
                  closed_in = 1'b1;
                  cell_init = !closed_ff;
                  dp0_in    = dp_base;
                  clen_in   = cl_base;
                  last_in   = req_data.word_end;
                  if (!req_data.no_char) begin
                     clen_in = cl_next;
                     dp0_in  = cl_next;
                     inj_in  = '{valid: 1'b1, ch: req_data.char_byte,
                                 diag: dp_base, left: cl_next};
                  end
                  if (!req_data.no_char && qlen_ff != '0) begin
                     state_in = ST_RUN;
                     cnt_in   = DIST_W'(1);
                  end else if (req_data.word_end) begin
                     state_in = ST_FIN;
                  end
               end
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == qlen_ff) begin
               state_in = last_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.distance        = result_dist;
               rsp_in.is_one_edit     = (result_dist == DIST_W'(1));
               rsp_in.length_overflow = ovf_ff || (clen_ff > MAX_LEN_V);
               rsp_valid_in           = 1'b1;
               cell_init              = 1'b1;
               dp0_in                 = '0;
               clen_in                = '0;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qlen_ff      <= '0;
         clen_ff      <= '0;
         ovf_ff       <= 1'b0;
         closed_ff    <= 1'b0;
         dp0_ff       <= '0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         inj_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qlen_ff      <= qlen_in;
         clen_ff      <= clen_in;
         ovf_ff       <= ovf_in;
         closed_ff    <= closed_in;
         dp0_ff       <= dp0_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         inj_ff.valid <= inj_in.valid;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inj_ff.ch   <= inj_in.ch;
      inj_ff.diag <= inj_in.diag;
      inj_ff.left <= inj_in.left;
      rsp_ff      <= rsp_in;
   end

   assign wave[0]   = inj_ff;
   assign dp_vec[0] = dp0_ff;

   for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
      cell_ctrl_type cell_ctrl;
      assign cell_ctrl.init      = cell_init;
      assign cell_ctrl.load      = char_load && (char_idx == DIST_W'(k - 1));
      assign cell_ctrl.load_char = req_data.char_byte;
      if (k < MAX_LEN) begin : g_mid
         edof_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .init_value (DIST_W'(k)),
            .wave_in    (wave[k-1]),
            .wave_out   (wave[k]),
            .dp_out     (dp_vec[k])
         );
      end else begin : g_tail
         edof_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .init_value (DIST_W'(k)),
            .wave_in    (wave[k-1]),
            .wave_out   (),
            .dp_out     (dp_vec[k])
         );
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/edof_checker.sv]
// port-level assertions for the edit distance filter, bound to the top level
module edof_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input edof_pkg::req_beat_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input edof_pkg::rsp_beat_type rsp_data
);
   import edof_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_one_edit == (rsp_data.distance == DIST_W'(1))))
      else $error("one-edit flag disagrees with distance");

   // query beats never raise a result
   a_query_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == MODE_QUERY |=> !$rose(rsp_valid))
      else $error("result after a query beat");

   // a word end of a candidate keeps the input closed while the result forms
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == MODE_CAND && req_data.word_end
      |=> !req_ready)
      else $error("input open right after candidate word end");

endmodule

bind edit_distance_one_filter edof_checker u_edof_checker (.*);
